/* hw/rtl/dlpt_pkg.sv */
// Shared constants for the DHCP lease pool table: table depth, field widths,
// register indexes, register reset values, message codes and command codes. No dependencies.
`default_nettype none
package dlpt_pkg;

  // Table depth and derived widths
  localparam int MAX_LEASES = 16;
  localparam int IDX_W      = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;
  localparam int CNT_W      = $clog2(MAX_LEASES + 1);

  // Field widths
  localparam int MAC_W   = 48;
  localparam int TIME_W  = 32;
  localparam int OCTET_W = 8;
  localparam int PFX_W   = 24;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_END      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PREFIX = 2'd3;

  // Register reset values
  localparam logic [OCTET_W-1:0] POOL_START_RST = 8'd100;
  localparam logic [OCTET_W-1:0] POOL_END_RST   = 8'd115;
  localparam logic [TIME_W-1:0]  LEASE_TIME_RST = 32'd3600;
  localparam logic [PFX_W-1:0]   PREFIX_RST     = 24'd0;

  // Message type codes
  localparam logic [OCTET_W-1:0] MSG_DISCOVER = 8'd1;
  localparam logic [OCTET_W-1:0] MSG_REQUEST  = 8'd3;

  // Command codes
  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_CLEANUP = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/dhcp_lease_pool_table_core.sv */
// DHCP lease pool table: sequencer walking the lease entries one per cycle.
// Depends on dlpt_pkg for widths, register indexes and message codes.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one transaction: a client
//   message (discover or request) or a cleanup sweep. in_stall stays high
//   from acceptance until the result transaction has left, so one item is
//   in flight at a time.
//   Output channel (out_valid / out_stall) returns exactly one transaction
//   per item; reply_valid is 0 when no lease was granted.
//   Sequence: capture, then a walk over the active pool entries
//   at one entry per cycle through a single compare/subtract unit, then the
//   result register. The walk covers up to size entries (size = active
//   pool size, at most MAX_LEASES); a renewal hit ends the walk early.
//   Reset (rst_n low, synchronous) clears all lease valid bits and loads the
//   register defaults; the block is ready in the first cycle after reset.
//   A stalled result holds in its register until out_stall drops.
//   Writing pool_start or pool_end clears the table at once.
`default_nettype none
module dhcp_lease_pool_table_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [dlpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dlpt_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_command,
  input  wire logic [dlpt_pkg::OCTET_W-1:0]   in_msg_type,
  input  wire logic [dlpt_pkg::MAC_W-1:0]     in_client_mac,
  input  wire logic [dlpt_pkg::TIME_W-1:0]    in_now_seconds,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_reply_valid,
  output logic                                out_reply_kind,
  output logic [dlpt_pkg::OCTET_W-1:0]        out_lease_index,
  output logic [2*dlpt_pkg::TIME_W/2-1:0]     out_offered_ip,
  output logic                                out_renewed
);
  import dlpt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_RESP
  } state_t;

  // control state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      size_r, size_nxt;
  logic                  free_seen_r, free_seen_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [MAX_LEASES-1:0] used_r, used_nxt;

  // configuration registers
  logic [OCTET_W-1:0]    pool_start_r;
  logic [OCTET_W-1:0]    pool_end_r;
  logic [TIME_W-1:0]     lease_time_r;
  logic [PFX_W-1:0]      prefix_r;

  // captured transaction
  logic                  req_r, req_nxt;
  logic [MAC_W-1:0]      mac_r, mac_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;

  // result register
  logic                  rep_valid_r, rep_valid_nxt;
  logic                  rep_kind_r, rep_kind_nxt;
  logic [OCTET_W-1:0]    rep_idx_r, rep_idx_nxt;
  logic [TIME_W-1:0]     rep_ip_r, rep_ip_nxt;
  logic                  renewed_r, renewed_nxt;

  // entry storage, written at one index per cycle
  logic [MAC_W-1:0]      entry_mac_r   [MAX_LEASES];
  logic [TIME_W-1:0]     entry_start_r [MAX_LEASES];
  logic [TIME_W-1:0]     entry_dur_r   [MAX_LEASES];
  logic                  ent_we;
  logic                  ent_mac_we;
  logic [IDX_W-1:0]      ent_widx;

  // walk datapath
  logic [IDX_W-1:0]      cur;
  logic                  scan_end;
  logic                  mac_hit;
  logic                  expired;
  logic [TIME_W-1:0]     age;
  logic [OCTET_W:0]      span;
  logic                  bound_wr;

  assign cur      = idx_r[IDX_W-1:0];
  assign scan_end = (idx_r == size_r);
  assign mac_hit  = used_r[cur] && (entry_mac_r[cur] == mac_r);
  assign age      = now_r - entry_start_r[cur];
  assign expired  = used_r[cur] && (age >= entry_dur_r[cur]);
  assign bound_wr = cfg_we && ((cfg_index == CFG_POOL_START) || (cfg_index == CFG_POOL_END));

  // active pool size, zero if pool_end is below pool_start, saturated at the table depth
  assign span = {1'b0, pool_end_r} - {1'b0, pool_start_r} + (OCTET_W+1)'(1);

  always_comb begin
    if (pool_end_r < pool_start_r) begin
      size_nxt = '0;
    end else if (span > (OCTET_W+1)'(MAX_LEASES)) begin
      size_nxt = CNT_W'(MAX_LEASES);
    end else begin
      size_nxt = CNT_W'(span);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    free_seen_nxt = free_seen_r;
    free_idx_nxt  = free_idx_r;
    used_nxt      = used_r;
    req_nxt       = req_r;
    mac_nxt       = mac_r;
    now_nxt       = now_r;
    rep_valid_nxt = rep_valid_r;
    rep_kind_nxt  = rep_kind_r;
    rep_idx_nxt   = rep_idx_r;
    rep_ip_nxt    = rep_ip_r;
    renewed_nxt   = renewed_r;
    ent_we        = 1'b0;
    ent_mac_we    = 1'b0;
    ent_widx      = cur;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // capture the transaction and clear the result
          req_nxt       = (in_msg_type == MSG_REQUEST);
          mac_nxt       = in_client_mac;
          now_nxt       = in_now_seconds;
          idx_nxt       = '0;
          free_seen_nxt = 1'b0;
          rep_valid_nxt = 1'b0;
          rep_kind_nxt  = 1'b0;
          rep_idx_nxt   = '0;
          rep_ip_nxt    = '0;
          renewed_nxt   = 1'b0;
          if (in_command == CMD_CLEANUP) begin
            state_nxt = ST_SWEEP;
          end else if ((in_msg_type == MSG_DISCOVER) || (in_msg_type == MSG_REQUEST)) begin
            state_nxt = ST_LOOKUP;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_LOOKUP: begin
        if (scan_end) begin
          // no renewal: claim the first free entry if any
          if (free_seen_r) begin
            used_nxt[free_idx_r] = 1'b1;
            ent_we        = 1'b1;
            ent_mac_we    = 1'b1;
            ent_widx      = free_idx_r;
            rep_valid_nxt = 1'b1;
            rep_kind_nxt  = req_r;
            rep_idx_nxt   = OCTET_W'(free_idx_r);
            rep_ip_nxt    = {prefix_r, pool_start_r + OCTET_W'(free_idx_r)};
          end
          state_nxt = ST_RESP;
        end else if (mac_hit) begin
          // renew the matching entry
          ent_we        = 1'b1;
          rep_valid_nxt = 1'b1;
          rep_kind_nxt  = req_r;
          rep_idx_nxt   = OCTET_W'(cur);
          rep_ip_nxt    = {prefix_r, pool_start_r + OCTET_W'(cur)};
          renewed_nxt   = 1'b1;
          state_nxt     = ST_RESP;
        end else begin
          if (!used_r[cur] && !free_seen_r) begin
            free_seen_nxt = 1'b1;
            free_idx_nxt  = cur;
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_SWEEP: begin
        if (scan_end) begin
          state_nxt = ST_RESP;
        end else begin
          // drop an expired lease
          if (expired) begin
            used_nxt[cur] = 1'b0;
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // pool bound writes empty the table
    if (bound_wr) begin
      used_nxt = '0;
    end
  end

  // control state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      size_r       <= '0;
      free_seen_r  <= 1'b0;
      free_idx_r   <= '0;
      used_r       <= '0;
      pool_start_r <= POOL_START_RST;
      pool_end_r   <= POOL_END_RST;
      lease_time_r <= LEASE_TIME_RST;
      prefix_r     <= PREFIX_RST;
      rep_valid_r  <= 1'b0;
      rep_kind_r   <= 1'b0;
      rep_idx_r    <= '0;
      rep_ip_r     <= '0;
      renewed_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      free_seen_r <= free_seen_nxt;
      free_idx_r  <= free_idx_nxt;
      used_r      <= used_nxt;
      rep_valid_r <= rep_valid_nxt;
      rep_kind_r  <= rep_kind_nxt;
      rep_idx_r   <= rep_idx_nxt;
      rep_ip_r    <= rep_ip_nxt;
      renewed_r   <= renewed_nxt;
      if (state_r == ST_IDLE) begin
        size_r <= size_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_START:    pool_start_r <= cfg_data[OCTET_W-1:0];
          CFG_POOL_END:      pool_end_r   <= cfg_data[OCTET_W-1:0];
          CFG_LEASE_TIME:    lease_time_r <= cfg_data[TIME_W-1:0];
          CFG_SERVER_PREFIX: prefix_r     <= cfg_data[PFX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    mac_r <= mac_nxt;
    now_r <= now_nxt;
  end

  // entry storage writes
  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_start_r[ent_widx] <= now_r;
      entry_dur_r[ent_widx]   <= lease_time_r;
    end
    if (ent_mac_we) begin
      entry_mac_r[ent_widx] <= mac_r;
    end
  end

  // ports
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_RESP);
  assign out_reply_valid = rep_valid_r;
  assign out_reply_kind  = rep_kind_r;
  assign out_lease_index = rep_idx_r;
  assign out_offered_ip  = rep_ip_r;
  assign out_renewed     = renewed_r;

endmodule
`default_nettype wire
